// File: sv/i2c_master_bit_engine_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define I2CM_ASSERT_DIS(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define I2CM_ASSERT_ALL(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/i2cm_pkg.sv
package i2cm_pkg;

  // Default width of the quarter-period register
  localparam int DELAY_BITS_DEFAULT = 10;
  // Quarter-period delay after reset
  localparam int RESET_DELAY = 25;
  // Clocks sent by bus recovery before the stop
  localparam logic [3:0] RECOVERY_CLOCKS = 4'd9;
  // Bits in one byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [2:0] {
    CMD_RECOVER = 3'd0,
    CMD_START   = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_STOP    = 3'd4
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_REC_LOW   = 5'd1,
    PH_REC_HIGH  = 5'd2,
    PH_START     = 5'd3,
    PH_BIT_LOW   = 5'd4,
    PH_BIT_SET   = 5'd5,
    PH_BIT_HIGH  = 5'd6,
    PH_ACK_LOW   = 5'd7,
    PH_ACK_HIGH  = 5'd8,
    PH_ACK_RETRY = 5'd9,
    PH_RD_LOW    = 5'd10,
    PH_RD_HIGH   = 5'd11,
    PH_RA_LOW    = 5'd12,
    PH_RA_HIGH   = 5'd13,
    PH_STOP_LOW  = 5'd14,
    PH_STOP_HIGH = 5'd15,
    PH_STOP_END  = 5'd16
  } phase_t;

  // One tick as offered on the input channel
  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [6:0] target_address;
    logic       read_not_write;
    logic [7:0] tx_byte;
    logic       ack_after_read;
    logic       scl_in;
    logic       sda_in;
  } item_t;

  // Result of one tick
  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       nack_error;
  } result_t;

endpackage

// File: sv/i2c_master_bit_engine_unit.sv
// Channel   Handshake                Payload
// in        in_valid / in_ready      cmd_valid mode target_address read_not_write
//                                    tx_byte ack_after_read scl_in sda_in
// out       out_valid / out_ready    scl_drive_low sda_drive_low busy_res done_res
//                                    rx_byte nack_error
// cfg       cfg_we                   cfg_wdata (quarter delay)
//
// One tick per cycle while the output is not stalled: a tick enters the input register,
// then one pass of engine logic updates the bus state and loads the result register.
// The engine state register advances with each tick that moves into the result register.
// rst is synchronous and active high; the quarter delay comes back at 25.
// A stalled output holds the result register and, behind it, the input register.
module i2c_master_bit_engine_unit #(
  parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [DELAY_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  cmd_valid,
  input  logic [2:0]            mode,
  input  logic [6:0]            target_address,
  input  logic                  read_not_write,
  input  logic [7:0]            tx_byte,
  input  logic                  ack_after_read,
  input  logic                  scl_in,
  input  logic                  sda_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  scl_drive_low,
  output logic                  sda_drive_low,
  output logic                  busy_res,
  output logic                  done_res,
  output logic [7:0]            rx_byte,
  output logic                  nack_error
);

  i2cm_pkg::item_t   in_item;
  i2cm_pkg::item_t   item;
  i2cm_pkg::result_t result;
  logic              drain_ready;
  logic              take;

  // Gather the input fields
  always_comb begin
    in_item.cmd_valid      = cmd_valid;
    in_item.mode           = mode;
    in_item.target_address = target_address;
    in_item.read_not_write = read_not_write;
    in_item.tx_byte        = tx_byte;
    in_item.ack_after_read = ack_after_read;
    in_item.scl_in         = scl_in;
    in_item.sda_in         = sda_in;
  end

  // Result register can load when empty or being drained
  assign drain_ready = ~out_valid | out_ready;

  i2cm_input_stage u_input (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .drain_ready (drain_ready),
    .take        (take),
    .item        (item)
  );

  i2cm_engine #(
    .DELAY_BITS (DELAY_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .item      (item),
    .result    (result)
  );

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (take) begin
      scl_drive_low <= result.scl_drive_low;
      sda_drive_low <= result.sda_drive_low;
      busy_res      <= result.busy_res;
      done_res      <= result.done_res;
      rx_byte       <= result.rx_byte;
      nack_error    <= result.nack_error;
    end
  end

endmodule

// File: sv/i2cm_input_stage.sv
module i2cm_input_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cm_pkg::item_t in_item,
  input  logic            drain_ready,
  output logic            take,
  output i2cm_pkg::item_t item
);

  logic s1_valid;
  logic accept;

  // Free the stage when it is empty or its tick moves on this cycle
  assign take     = s1_valid & drain_ready;
  assign in_ready = ~s1_valid | drain_ready;
  assign accept   = in_valid & in_ready;

  // Hold the occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the tick on each transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

endmodule

// File: sv/i2cm_engine.sv
module i2cm_engine #(
  parameter int DELAY_BITS = i2cm_pkg::DELAY_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [DELAY_BITS-1:0] cfg_wdata,
  input  logic                  take,
  input  i2cm_pkg::item_t       item,
  output i2cm_pkg::result_t     result
);

  localparam int CW = DELAY_BITS + 1;

  logic [DELAY_BITS-1:0] quarter_delay;
  i2cm_pkg::phase_t      phase, phase_next;
  i2cm_pkg::cmd_t        current_command, current_command_next;
  logic [CW-1:0]         delay_count, delay_count_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [7:0]            shift_reg, shift_reg_next;
  logic [3:0]            recovery_count, recovery_count_next;
  logic                  ack_choice, ack_choice_next;
  logic [7:0]            received_byte, received_byte_next;
  logic                  nack_flag, nack_flag_next;
  logic                  scl_drive, scl_drive_next;
  logic                  sda_drive, sda_drive_next;
  logic                  done;

  logic [DELAY_BITS-1:0] d;
  logic [CW-1:0]         d_ext;
  logic [CW-1:0]         d2;
  logic [CW-1:0]         dc_inc;
  logic                  past_d;
  logic                  past_d2;
  logic                  high_ok;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_delay <= DELAY_BITS'(i2cm_pkg::RESET_DELAY);
    end else if (cfg_we) begin
      quarter_delay <= cfg_wdata;
    end
  end

  // Phase timing: a zero delay counts as one, counter saturates at two quarters
  assign d       = (quarter_delay == '0) ? DELAY_BITS'(1) : quarter_delay;
  assign d_ext   = {1'b0, d};
  assign d2      = {d, 1'b0};
  assign dc_inc  = (delay_count < d2) ? delay_count + CW'(1) : delay_count;
  assign past_d  = dc_inc >= d_ext;
  assign past_d2 = dc_inc >= d2;
  assign high_ok = past_d2 & item.scl_in;

  // Next state for one tick
  always_comb begin
    phase_next           = phase;
    current_command_next = current_command;
    delay_count_next     = delay_count;
    bit_count_next       = bit_count;
    shift_reg_next       = shift_reg;
    recovery_count_next  = recovery_count;
    ack_choice_next      = ack_choice;
    received_byte_next   = received_byte;
    nack_flag_next       = nack_flag;
    scl_drive_next       = scl_drive;
    sda_drive_next       = sda_drive;
    done                 = 1'b0;

    if (phase == i2cm_pkg::PH_IDLE) begin
      // Take a command; unknown modes are dropped
      if (item.cmd_valid && item.mode <= i2cm_pkg::CMD_STOP) begin
        current_command_next = i2cm_pkg::cmd_t'(item.mode);
        delay_count_next     = '0;
        case (item.mode)
          i2cm_pkg::CMD_RECOVER: begin
            recovery_count_next = '0;
            sda_drive_next      = 1'b0;
            scl_drive_next      = 1'b1;
            phase_next          = i2cm_pkg::PH_REC_LOW;
          end
          i2cm_pkg::CMD_START: begin
            nack_flag_next = 1'b0;
            shift_reg_next = {item.target_address, item.read_not_write};
            bit_count_next = '0;
            scl_drive_next = 1'b0;
            sda_drive_next = 1'b1;
            phase_next     = i2cm_pkg::PH_START;
          end
          i2cm_pkg::CMD_WRITE: begin
            nack_flag_next = 1'b0;
            shift_reg_next = item.tx_byte;
            bit_count_next = '0;
            scl_drive_next = 1'b1;
            phase_next     = i2cm_pkg::PH_BIT_LOW;
          end
          i2cm_pkg::CMD_READ: begin
            ack_choice_next = item.ack_after_read;
            shift_reg_next  = '0;
            bit_count_next  = '0;
            scl_drive_next  = 1'b1;
            phase_next      = i2cm_pkg::PH_RD_LOW;
          end
          default: begin
            scl_drive_next = 1'b1;
            phase_next     = i2cm_pkg::PH_STOP_LOW;
          end
        endcase
      end
    end else begin
      delay_count_next = dc_inc;
      unique case (phase)
        i2cm_pkg::PH_REC_LOW: begin
          if (past_d) begin
            scl_drive_next   = 1'b0;
            phase_next       = i2cm_pkg::PH_REC_HIGH;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_REC_HIGH: begin
          if (high_ok) begin
            recovery_count_next = recovery_count + 4'd1;
            scl_drive_next      = 1'b1;
            delay_count_next    = '0;
            phase_next = (recovery_count_next >= i2cm_pkg::RECOVERY_CLOCKS)
                         ? i2cm_pkg::PH_STOP_LOW : i2cm_pkg::PH_REC_LOW;
          end
        end
        i2cm_pkg::PH_START: begin
          if (past_d) begin
            scl_drive_next   = 1'b1;
            phase_next       = i2cm_pkg::PH_BIT_LOW;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_BIT_LOW: begin
          if (past_d) begin
            sda_drive_next   = ~shift_reg[7];
            phase_next       = i2cm_pkg::PH_BIT_SET;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_BIT_SET: begin
          if (past_d) begin
            scl_drive_next   = 1'b0;
            phase_next       = i2cm_pkg::PH_BIT_HIGH;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_BIT_HIGH: begin
          if (high_ok) begin
            shift_reg_next   = {shift_reg[6:0], 1'b0};
            bit_count_next   = bit_count + 4'd1;
            scl_drive_next   = 1'b1;
            delay_count_next = '0;
            if (bit_count_next >= i2cm_pkg::BYTE_BITS) begin
              sda_drive_next = 1'b0;
              phase_next     = i2cm_pkg::PH_ACK_LOW;
            end else begin
              phase_next = i2cm_pkg::PH_BIT_LOW;
            end
          end
        end
        i2cm_pkg::PH_ACK_LOW: begin
          if (past_d2) begin
            scl_drive_next   = 1'b0;
            phase_next       = i2cm_pkg::PH_ACK_HIGH;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_ACK_HIGH: begin
          // First ack sample at the end of the high phase
          if (high_ok) begin
            if (!item.sda_in) begin
              scl_drive_next = 1'b1;
              phase_next     = i2cm_pkg::PH_IDLE;
              done           = 1'b1;
            end else begin
              phase_next       = i2cm_pkg::PH_ACK_RETRY;
              delay_count_next = '0;
            end
          end
        end
        i2cm_pkg::PH_ACK_RETRY: begin
          // Second ack sample one quarter later; a nack on the address sends a stop
          if (past_d) begin
            if (!item.sda_in) begin
              scl_drive_next = 1'b1;
              phase_next     = i2cm_pkg::PH_IDLE;
              done           = 1'b1;
            end else begin
              nack_flag_next = 1'b1;
              if (current_command == i2cm_pkg::CMD_START) begin
                scl_drive_next   = 1'b1;
                phase_next       = i2cm_pkg::PH_STOP_LOW;
                delay_count_next = '0;
              end else begin
                phase_next = i2cm_pkg::PH_IDLE;
                done       = 1'b1;
              end
            end
          end
        end
        i2cm_pkg::PH_RD_LOW: begin
          if (past_d) begin
            sda_drive_next   = 1'b0;
            scl_drive_next   = 1'b0;
            phase_next       = i2cm_pkg::PH_RD_HIGH;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_RD_HIGH: begin
          if (high_ok) begin
            shift_reg_next   = {shift_reg[6:0], item.sda_in};
            bit_count_next   = bit_count + 4'd1;
            scl_drive_next   = 1'b1;
            delay_count_next = '0;
            if (bit_count_next >= i2cm_pkg::BYTE_BITS) begin
              received_byte_next = shift_reg_next;
              phase_next         = i2cm_pkg::PH_RA_LOW;
            end else begin
              phase_next = i2cm_pkg::PH_RD_LOW;
            end
          end
        end
        i2cm_pkg::PH_RA_LOW: begin
          if (past_d) begin
            sda_drive_next   = ack_choice;
            scl_drive_next   = 1'b0;
            phase_next       = i2cm_pkg::PH_RA_HIGH;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_RA_HIGH: begin
          if (high_ok) begin
            phase_next = i2cm_pkg::PH_IDLE;
            done       = 1'b1;
          end
        end
        i2cm_pkg::PH_STOP_LOW: begin
          if (past_d) begin
            sda_drive_next   = 1'b1;
            scl_drive_next   = 1'b0;
            phase_next       = i2cm_pkg::PH_STOP_HIGH;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_STOP_HIGH: begin
          if (high_ok) begin
            sda_drive_next   = 1'b0;
            phase_next       = i2cm_pkg::PH_STOP_END;
            delay_count_next = '0;
          end
        end
        i2cm_pkg::PH_STOP_END: begin
          if (past_d) begin
            phase_next = i2cm_pkg::PH_IDLE;
            done       = 1'b1;
          end
        end
        default: begin
          phase_next = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Advance the engine state once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= i2cm_pkg::PH_IDLE;
      current_command <= i2cm_pkg::CMD_RECOVER;
      delay_count     <= '0;
      bit_count       <= '0;
      shift_reg       <= '0;
      recovery_count  <= '0;
      ack_choice      <= 1'b0;
      received_byte   <= '0;
      nack_flag       <= 1'b0;
      scl_drive       <= 1'b0;
      sda_drive       <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      current_command <= current_command_next;
      delay_count     <= delay_count_next;
      bit_count       <= bit_count_next;
      shift_reg       <= shift_reg_next;
      recovery_count  <= recovery_count_next;
      ack_choice      <= ack_choice_next;
      received_byte   <= received_byte_next;
      nack_flag       <= nack_flag_next;
      scl_drive       <= scl_drive_next;
      sda_drive       <= sda_drive_next;
    end
  end

  // Result of this tick, taken from the state after it
  always_comb begin
    result.scl_drive_low = scl_drive_next;
    result.sda_drive_low = sda_drive_next;
    result.busy_res      = (phase_next != i2cm_pkg::PH_IDLE);
    result.done_res      = done;
    result.rx_byte       = received_byte_next;
    result.nack_error    = nack_flag_next;
  end

endmodule

// File: sv/i2cm_checker.sv
`include "i2c_master_bit_engine_unit_macros.svh"

module i2cm_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_drive_low,
  input logic       sda_drive_low,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rx_byte,
  input logic       nack_error
);

  // Reset empties the result register
  `I2CM_ASSERT_ALL(a_reset_empty, clk, rst |=> !out_valid, "result valid after reset")

  // A finishing tick never reports busy
  `I2CM_ASSERT_DIS(a_done_not_busy, clk, rst, out_valid && done_res |-> !busy_res, "done while busy")

  // A stalled result holds
  `I2CM_ASSERT_DIS(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable({scl_drive_low, sda_drive_low, busy_res, done_res, rx_byte, nack_error}), "stalled result changed")

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .scl_drive_low (scl_drive_low),
  .sda_drive_low (sda_drive_low),
  .busy_res      (busy_res),
  .done_res      (done_res),
  .rx_byte       (rx_byte),
  .nack_error    (nack_error)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DW = i2cm_pkg::DELAY_BITS_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // How the simulated slave answers an ack slot
  typedef enum logic [1:0] {
    ACK_YES,
    ACK_NO,
    ACK_LATE
  } ack_plan_t;

  // Tracks the engine tick by tick and holds the line states it must produce
  class i2c_tick_tracker;
    logic [DW-1:0]     qdelay = DW'(i2cm_pkg::RESET_DELAY);
    i2cm_pkg::phase_t  ph = i2cm_pkg::PH_IDLE;
    i2cm_pkg::cmd_t    cur_cmd = i2cm_pkg::CMD_RECOVER;
    int unsigned       dcount = 0;
    logic [3:0]        bits = '0;
    logic [3:0]        rec_cnt = '0;
    logic [7:0]        shreg = '0;
    logic [7:0]        rx_last = '0;
    logic              ack_sel = 1'b0;
    logic              nack = 1'b0;
    logic              scl_lo = 1'b0;
    logic              sda_lo = 1'b0;
    i2cm_pkg::result_t line_expect[$];
    int                failures = 0;
    int                compared = 0;
    int                finished = 0;
    int                nacks = 0;

    function void go(i2cm_pkg::phase_t p);
      ph = p;
      dcount = 0;
    endfunction

    function int pending();
      return line_expect.size();
    endfunction

    // Advance one tick; returns 1 when the engine worked on this tick
    function bit note_tick(i2cm_pkg::item_t t);
      int unsigned       d;
      int unsigned       d2;
      bit                high_ok;
      logic              done;
      i2cm_pkg::result_t r;
      d = (qdelay == '0) ? 1 : int'(qdelay);
      d2 = 2 * d;
      done = 1'b0;
      if (ph == i2cm_pkg::PH_IDLE) begin
        // take a command only when idle and the mode is known
        if (t.cmd_valid && t.mode <= i2cm_pkg::CMD_STOP) begin
          cur_cmd = i2cm_pkg::cmd_t'(t.mode);
          case (cur_cmd)
            i2cm_pkg::CMD_RECOVER: begin
              rec_cnt = '0;
              sda_lo = 1'b0;
              scl_lo = 1'b1;
              go(i2cm_pkg::PH_REC_LOW);
            end
            i2cm_pkg::CMD_START: begin
              nack = 1'b0;
              shreg = {t.target_address, t.read_not_write};
              bits = '0;
              scl_lo = 1'b0;
              sda_lo = 1'b1;
              go(i2cm_pkg::PH_START);
            end
            i2cm_pkg::CMD_WRITE: begin
              nack = 1'b0;
              shreg = t.tx_byte;
              bits = '0;
              scl_lo = 1'b1;
              go(i2cm_pkg::PH_BIT_LOW);
            end
            i2cm_pkg::CMD_READ: begin
              ack_sel = t.ack_after_read;
              shreg = '0;
              bits = '0;
              scl_lo = 1'b1;
              go(i2cm_pkg::PH_RD_LOW);
            end
            default: begin
              scl_lo = 1'b1;
              go(i2cm_pkg::PH_STOP_LOW);
            end
          endcase
        end
      end else begin
        if (dcount < d2) dcount++;
        high_ok = (dcount >= d2) && t.scl_in;
        case (ph) inside
          i2cm_pkg::PH_REC_LOW: begin
            if (dcount >= d) begin
              scl_lo = 1'b0;
              go(i2cm_pkg::PH_REC_HIGH);
            end
          end
          i2cm_pkg::PH_REC_HIGH: begin
            if (high_ok) begin
              rec_cnt = rec_cnt + 4'd1;
              scl_lo = 1'b1;
              go(rec_cnt >= i2cm_pkg::RECOVERY_CLOCKS ? i2cm_pkg::PH_STOP_LOW
                                                      : i2cm_pkg::PH_REC_LOW);
            end
          end
          i2cm_pkg::PH_START: begin
            if (dcount >= d) begin
              scl_lo = 1'b1;
              go(i2cm_pkg::PH_BIT_LOW);
            end
          end
          i2cm_pkg::PH_BIT_LOW: begin
            if (dcount >= d) begin
              sda_lo = ~shreg[7];
              go(i2cm_pkg::PH_BIT_SET);
            end
          end
          i2cm_pkg::PH_BIT_SET: begin
            if (dcount >= d) begin
              scl_lo = 1'b0;
              go(i2cm_pkg::PH_BIT_HIGH);
            end
          end
          i2cm_pkg::PH_BIT_HIGH: begin
            if (high_ok) begin
              shreg = {shreg[6:0], 1'b0};
              bits = bits + 4'd1;
              scl_lo = 1'b1;
              if (bits >= i2cm_pkg::BYTE_BITS) begin
                sda_lo = 1'b0;
                go(i2cm_pkg::PH_ACK_LOW);
              end else begin
                go(i2cm_pkg::PH_BIT_LOW);
              end
            end
          end
          i2cm_pkg::PH_ACK_LOW: begin
            if (dcount >= d2) begin
              scl_lo = 1'b0;
              go(i2cm_pkg::PH_ACK_HIGH);
            end
          end
          i2cm_pkg::PH_ACK_HIGH, i2cm_pkg::PH_ACK_RETRY: begin
            // first sample at the end of the high phase, second one delay later
            if ((ph == i2cm_pkg::PH_ACK_HIGH) ? high_ok : (dcount >= d)) begin
              if (!t.sda_in) begin
                scl_lo = 1'b1;
                ph = i2cm_pkg::PH_IDLE;
                done = 1'b1;
              end else if (ph == i2cm_pkg::PH_ACK_HIGH) begin
                go(i2cm_pkg::PH_ACK_RETRY);
              end else begin
                nack = 1'b1;
                nacks++;
                if (cur_cmd == i2cm_pkg::CMD_START) begin
                  scl_lo = 1'b1;
                  go(i2cm_pkg::PH_STOP_LOW);
                end else begin
                  ph = i2cm_pkg::PH_IDLE;
                  done = 1'b1;
                end
              end
            end
          end
          i2cm_pkg::PH_RD_LOW: begin
            if (dcount >= d) begin
              sda_lo = 1'b0;
              scl_lo = 1'b0;
              go(i2cm_pkg::PH_RD_HIGH);
            end
          end
          i2cm_pkg::PH_RD_HIGH: begin
            if (high_ok) begin
              shreg = {shreg[6:0], t.sda_in};
              bits = bits + 4'd1;
              scl_lo = 1'b1;
              if (bits >= i2cm_pkg::BYTE_BITS) begin
                rx_last = shreg;
                go(i2cm_pkg::PH_RA_LOW);
              end else begin
                go(i2cm_pkg::PH_RD_LOW);
              end
            end
          end
          i2cm_pkg::PH_RA_LOW: begin
            if (dcount >= d) begin
              sda_lo = ack_sel;
              scl_lo = 1'b0;
              go(i2cm_pkg::PH_RA_HIGH);
            end
          end
          i2cm_pkg::PH_RA_HIGH: begin
            if (high_ok) begin
              ph = i2cm_pkg::PH_IDLE;
              done = 1'b1;
            end
          end
          i2cm_pkg::PH_STOP_LOW: begin
            if (dcount >= d) begin
              sda_lo = 1'b1;
              scl_lo = 1'b0;
              go(i2cm_pkg::PH_STOP_HIGH);
            end
          end
          i2cm_pkg::PH_STOP_HIGH: begin
            if (high_ok) begin
              sda_lo = 1'b0;
              go(i2cm_pkg::PH_STOP_END);
            end
          end
          i2cm_pkg::PH_STOP_END: begin
            if (dcount >= d) begin
              ph = i2cm_pkg::PH_IDLE;
              done = 1'b1;
            end
          end
          default: ph = i2cm_pkg::PH_IDLE;
        endcase
      end
      if (done) finished++;
      r.scl_drive_low = scl_lo;
      r.sda_drive_low = sda_lo;
      r.busy_res = (ph != i2cm_pkg::PH_IDLE);
      r.done_res = done;
      r.rx_byte = rx_last;
      r.nack_error = nack;
      line_expect.push_back(r);
      return r.busy_res || r.done_res;
    endfunction

    // Compare one transferred result with the oldest pending one
    function void check_result(i2cm_pkg::result_t got);
      i2cm_pkg::result_t want;
      compared++;
      if (line_expect.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: result transferred with nothing pending", $time);
        return;
      end
      want = line_expect.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("%0t: expected scl=%b sda=%b busy=%b done=%b rx=%02h nack=%b", $time,
                   want.scl_drive_low, want.sda_drive_low, want.busy_res, want.done_res,
                   want.rx_byte, want.nack_error);
          $display("%0t:      got scl=%b sda=%b busy=%b done=%b rx=%02h nack=%b", $time,
                   got.scl_drive_low, got.sda_drive_low, got.busy_res, got.done_res,
                   got.rx_byte, got.nack_error);
        end
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [DW-1:0] cfg_wdata = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          cmd_valid = 1'b0;
  logic [2:0]    mode = '0;
  logic [6:0]    target_address = '0;
  logic          read_not_write = 1'b0;
  logic [7:0]    tx_byte = '0;
  logic          ack_after_read = 1'b0;
  logic          scl_in = 1'b1;
  logic          sda_in = 1'b1;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          scl_drive_low;
  logic          sda_drive_low;
  logic          busy_res;
  logic          done_res;
  logic [7:0]    rx_byte;
  logic          nack_error;

  i2c_tick_tracker tracker;

  int        send_gap_pct = 0;
  int        recv_gap_pct = 0;
  ack_plan_t ack_plan = ACK_YES;
  logic [7:0] slave_byte = '0;
  int        stretch_left = 0;
  int        stuck_ticks = 0;
  int        total_ticks = 0;
  int        work_ticks = 0;
  int        commands_issued = 0;
  int        stall_cycles = 0;

  i2c_master_bit_engine_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd_valid      (cmd_valid),
    .mode           (mode),
    .target_address (target_address),
    .read_not_write (read_not_write),
    .tx_byte        (tx_byte),
    .ack_after_read (ack_after_read),
    .scl_in         (scl_in),
    .sda_in         (sda_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .scl_drive_low  (scl_drive_low),
    .sda_drive_low  (sda_drive_low),
    .busy_res       (busy_res),
    .done_res       (done_res),
    .rx_byte        (rx_byte),
    .nack_error     (nack_error)
  );

  always #5 clk = ~clk;

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result({scl_drive_low, sda_drive_low, busy_res, done_res,
                            rx_byte, nack_error});
  end

  // Drop the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic i2cm_pkg::item_t random_item();
    i2cm_pkg::item_t t;
    t.cmd_valid = 1'($urandom);
    t.mode = 3'($urandom);
    t.target_address = 7'($urandom);
    t.read_not_write = 1'($urandom);
    t.tx_byte = 8'($urandom);
    t.ack_after_read = 1'($urandom);
    t.scl_in = 1'($urandom);
    t.sda_in = 1'($urandom);
    return t;
  endfunction

  // Fill in the sampled bus levels: the engine's own drives, a slave, clock stretching
  function automatic i2cm_pkg::item_t on_bus(i2cm_pkg::item_t t);
    if (tracker.scl_lo) begin
      t.scl_in = 1'b0;
      stretch_left = ($urandom_range(99) < 15) ? $urandom_range(1, 5) : 0;
    end else if (tracker.ph == i2cm_pkg::PH_IDLE) begin
      t.scl_in = 1'($urandom);
    end else if (stuck_ticks > 0) begin
      t.scl_in = 1'b0;
      stuck_ticks--;
    end else if (stretch_left > 0) begin
      t.scl_in = 1'b0;
      stretch_left--;
    end else begin
      t.scl_in = 1'b1;
    end
    if (tracker.sda_lo) begin
      t.sda_in = 1'b0;
    end else begin
      case (tracker.ph) inside
        i2cm_pkg::PH_ACK_LOW, i2cm_pkg::PH_ACK_HIGH: t.sda_in = (ack_plan != ACK_YES);
        i2cm_pkg::PH_ACK_RETRY:                      t.sda_in = (ack_plan == ACK_NO);
        i2cm_pkg::PH_RD_LOW, i2cm_pkg::PH_RD_HIGH:
          t.sda_in = slave_byte[3'd7 - tracker.bits[2:0]];
        i2cm_pkg::PH_IDLE:                           t.sda_in = 1'($urandom);
        default:                                     t.sda_in = ($urandom_range(99) >= 3);
      endcase
    end
    return t;
  endfunction

  function automatic ack_plan_t pick_plan();
    int r;
    r = $urandom_range(99);
    if (r < 80) return ACK_YES;
    if (r < 90) return ACK_LATE;
    return ACK_NO;
  endfunction

  // Offer one tick and hold it until the transfer
  task automatic send_tick(input i2cm_pkg::item_t t);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_valid <= t.cmd_valid;
    mode <= t.mode;
    target_address <= t.target_address;
    read_not_write <= t.read_not_write;
    tx_byte <= t.tx_byte;
    ack_after_read <= t.ack_after_read;
    scl_in <= t.scl_in;
    sda_in <= t.sda_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tracker.note_tick(t)) work_ticks++;
    total_ticks++;
  endtask

  // Issue one command, then feed bus ticks until the engine is idle again
  task automatic issue_command(input i2cm_pkg::cmd_t m, input logic [6:0] addr,
                               input logic rw, input logic [7:0] data, input logic ack_rd,
                               input ack_plan_t plan);
    i2cm_pkg::item_t t;
    t = random_item();
    t.cmd_valid = 1'b1;
    t.mode = m;
    t.target_address = addr;
    t.read_not_write = rw;
    t.tx_byte = data;
    t.ack_after_read = ack_rd;
    ack_plan = plan;
    slave_byte = data;
    send_tick(on_bus(t));
    commands_issued++;
    while (tracker.ph != i2cm_pkg::PH_IDLE) begin
      // commands offered while busy must be ignored
      t = random_item();
      t.cmd_valid = ($urandom_range(99) < 4);
      send_tick(on_bus(t));
    end
  endtask

  // Idle ticks, some carrying an unknown mode
  task automatic idle_ticks(input int n);
    i2cm_pkg::item_t t;
    for (int i = 0; i < n; i++) begin
      t = random_item();
      if (t.cmd_valid) t.mode = 3'($urandom_range(5, 7));
      send_tick(on_bus(t));
    end
  endtask

  // Drain, then write the quarter delay
  task automatic set_quarter_delay(input logic [DW-1:0] v);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.qdelay = v;
  endtask

  // One bus transaction: mostly start, bytes, stop; sometimes a lone command
  task automatic random_transfer();
    int   kind;
    int   nbytes;
    logic rw;
    kind = $urandom_range(99);
    idle_ticks($urandom_range(0, 3));
    if (kind < 8) begin
      issue_command(i2cm_pkg::CMD_RECOVER, 7'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom), ACK_YES);
    end else if (kind < 13) begin
      issue_command(i2cm_pkg::CMD_STOP, 7'($urandom), 1'($urandom), 8'($urandom),
                    1'($urandom), ACK_YES);
    end else if (kind < 18) begin
      issue_command($urandom_range(1) ? i2cm_pkg::CMD_WRITE : i2cm_pkg::CMD_READ,
                    7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom), pick_plan());
    end else begin
      rw = 1'($urandom);
      issue_command(i2cm_pkg::CMD_START, 7'($urandom), rw, 8'($urandom), 1'($urandom),
                    pick_plan());
      // an address nack has already sent the stop
      if (!tracker.nack) begin
        nbytes = $urandom_range(0, 3);
        for (int i = 0; i < nbytes; i++) begin
          if (rw)
            issue_command(i2cm_pkg::CMD_READ, 7'($urandom), 1'($urandom), 8'($urandom),
                          (i != nbytes - 1), ACK_YES);
          else
            issue_command(i2cm_pkg::CMD_WRITE, 7'($urandom), 1'($urandom), 8'($urandom),
                          1'($urandom), pick_plan());
        end
        if ($urandom_range(9) != 0)
          issue_command(i2cm_pkg::CMD_STOP, '0, 1'b0, '0, 1'b0, ACK_YES);
      end
    end
  endtask

  initial begin : main_flow
    i2cm_pkg::item_t t;
    int              goal;
    tracker = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 11;
    recv_gap_pct = 60;

    // stop at the quarter delay left by reset
    issue_command(i2cm_pkg::CMD_STOP, '0, 1'b0, '0, 1'b0, ACK_YES);
    // a zero delay runs as one
    set_quarter_delay('0);
    // recovery with SCL held low by a slave for a while
    stuck_ticks = 50;
    issue_command(i2cm_pkg::CMD_RECOVER, '0, 1'b0, '0, 1'b0, ACK_YES);
    issue_command(i2cm_pkg::CMD_START, 7'h00, 1'b0, 8'h00, 1'b0, ACK_YES);
    issue_command(i2cm_pkg::CMD_WRITE, '0, 1'b0, 8'hFF, 1'b0, ACK_YES);
    // data nack only raises the flag and leaves SCL released
    issue_command(i2cm_pkg::CMD_WRITE, '0, 1'b0, 8'h00, 1'b0, ACK_NO);
    // ack seen only on the second sample
    issue_command(i2cm_pkg::CMD_WRITE, '0, 1'b0, 8'hA5, 1'b1, ACK_LATE);
    issue_command(i2cm_pkg::CMD_STOP, '0, 1'b0, '0, 1'b0, ACK_YES);
    issue_command(i2cm_pkg::CMD_START, 7'h7F, 1'b1, 8'hFF, 1'b1, ACK_YES);
    issue_command(i2cm_pkg::CMD_READ, '0, 1'b0, 8'hFF, 1'b1, ACK_YES);
    issue_command(i2cm_pkg::CMD_READ, '0, 1'b0, 8'h00, 1'b0, ACK_YES);
    issue_command(i2cm_pkg::CMD_STOP, '0, 1'b0, '0, 1'b0, ACK_YES);
    // address nack sends its own stop
    issue_command(i2cm_pkg::CMD_START, 7'h55, 1'b0, 8'h00, 1'b0, ACK_NO);
    issue_command(i2cm_pkg::CMD_START, 7'h2A, 1'b1, 8'h00, 1'b0, ACK_LATE);
    // unknown modes start nothing
    for (int m = 5; m <= 7; m++) begin
      t = random_item();
      t.cmd_valid = 1'b1;
      t.mode = 3'(m);
      send_tick(on_bus(t));
    end
    issue_command(i2cm_pkg::CMD_STOP, '0, 1'b0, '0, 1'b0, ACK_YES);

    // random traffic under three idling patterns
    for (int p = 0; p < 3; p++) begin
      send_gap_pct = (p == 0) ? 11 : (p == 1) ? 60 : 0;
      recv_gap_pct = (p == 0) ? 60 : (p == 1) ? 11 : 0;
      goal = work_ticks + 250;
      while (work_ticks < goal) begin
        if ($urandom_range(99) < 12) set_quarter_delay(DW'($urandom_range(0, 4)));
        random_transfer();
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Ran %0d bus ticks (%0d with the engine working) over %0d commands,",
             total_ticks, work_ticks, commands_issued);
    $display("quarter delays 0 to 4 and 25: %0d completions, %0d nacks, %0d results compared.",
             tracker.finished, tracker.nacks, tracker.compared);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: i2c_master_bit_engine_unit.f
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_input_stage.sv
sv/i2cm_engine.sv
sv/i2c_master_bit_engine_unit.sv
sv/i2cm_checker.sv
verif/testbench.sv
